// ----- hw/rtl/mfs_pkg.sv -----
package mfs_pkg;

    localparam int VTX_W   = 6;   // vertex index
    localparam int LVL_W   = 7;   // level / vertex count
    localparam int CAP_W   = 30;  // capacity
    localparam int FLOW_W  = 39;  // accumulated flow
    localparam int MASK_W  = 64;  // reachable mask
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINK         = 2'd2;

    // per-augmentation cap and capacity saturation value
    localparam logic [CAP_W-1:0] AUG_CAP = 30'd1000000000;

    // one stored residual edge
    typedef struct packed {
        logic [VTX_W-1:0] head;
        logic [VTX_W-1:0] tail;
        logic [CAP_W-1:0] cap;
    } edge_word_t;

endpackage

// ----- hw/rtl/mfs_ram.sv -----
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/max_flow_min_cut_solver_unit.sv -----
// max flow / min cut solver (dinic). edges arrive one request at a time and are
// written to the edge memory together with a zero-capacity reverse edge: a stored
// edge writes the forward edge and then the reverse edge, a dropped one writes
// nothing. the request flagged last_edge starts the solve; the block holds stall
// high until the result is loaded into the output register. the solve repeats
// phases of a breadth-first level build followed by blocking-flow walks.
// everything runs through edge, level, queue, pointer and stack memories with one
// write port, one read port and registered reads, so each edge examined needs an
// edge read, and one that leaves the current vertex with spare capacity also a
// level read. the edge memory port sets the pace. configuration must be written
// only while the block is idle; the user is bound by this, the block itself
// does not enforce it.
module max_flow_min_cut_solver_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // edge requests
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mfs_pkg::VTX_W-1:0]         edge_from,
    input  logic [mfs_pkg::VTX_W-1:0]         edge_to,
    input  logic [mfs_pkg::CAP_W-1:0]         capacity,
    input  logic                              last_edge,
    // result
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mfs_pkg::FLOW_W-1:0]        max_flow,
    output logic [mfs_pkg::MASK_W-1:0]        source_side_mask,
    output logic                              edges_dropped
);

    import mfs_pkg::*;

    localparam int EW  = $clog2(2 * MAX_EDGES);     // edge address
    localparam int VAW = $clog2(MAX_VERTICES);      // vertex memory address
    localparam int DW  = VAW + 1;                   // stack / queue counters

    // sequencer codes
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_LOAD_REV = 5'd1;
    localparam logic [4:0] S_START    = 5'd2;
    localparam logic [4:0] S_BFS_BEG  = 5'd3;
    localparam logic [4:0] S_LVL_INIT = 5'd4;
    localparam logic [4:0] S_BFS_POP  = 5'd5;
    localparam logic [4:0] S_BFS_U    = 5'd6;
    localparam logic [4:0] S_BFS_LU   = 5'd7;
    localparam logic [4:0] S_BFS_ERD  = 5'd8;
    localparam logic [4:0] S_BFS_ECHK = 5'd9;
    localparam logic [4:0] S_BFS_LCHK = 5'd10;
    localparam logic [4:0] S_BFS_END  = 5'd11;
    localparam logic [4:0] S_PTR_INIT = 5'd12;
    localparam logic [4:0] S_WALK     = 5'd13;
    localparam logic [4:0] S_W_GET    = 5'd14;
    localparam logic [4:0] S_W_ERD    = 5'd15;
    localparam logic [4:0] S_W_ECHK   = 5'd16;
    localparam logic [4:0] S_W_LCHK   = 5'd17;
    localparam logic [4:0] S_W_END    = 5'd18;
    localparam logic [4:0] S_RET_STK  = 5'd19;
    localparam logic [4:0] S_RET_EDGE = 5'd20;
    localparam logic [4:0] S_MIN_RD   = 5'd21;
    localparam logic [4:0] S_MIN_STK  = 5'd22;
    localparam logic [4:0] S_MIN_CMP  = 5'd23;
    localparam logic [4:0] S_UPD_RD   = 5'd24;
    localparam logic [4:0] S_UPD_STK  = 5'd25;
    localparam logic [4:0] S_UPD_FWD  = 5'd26;
    localparam logic [4:0] S_UPD_REV  = 5'd27;
    localparam logic [4:0] S_EMIT     = 5'd28;

    // control state
    logic [4:0]            state_reg, state_next;
    logic [EW-1:0]         cnt_reg, cnt_next;
    logic                  drop_reg, drop_next;
    logic [FLOW_W-1:0]     flow_reg, flow_next;
    logic                  oval_reg, oval_next;
    logic [LVL_W-1:0]      vc_reg, vc_next;
    logic [VTX_W-1:0]      src_reg, src_next;
    logic [VTX_W-1:0]      snk_reg, snk_next;

    // working registers
    logic [VTX_W-1:0]      ld_tail_reg, ld_tail_next;
    logic [VTX_W-1:0]      ld_head_reg, ld_head_next;
    logic                  ld_last_reg, ld_last_next;
    logic [VTX_W-1:0]      v_reg, v_next;
    logic [VTX_W-1:0]      u_reg, u_next;
    logic [VTX_W-1:0]      hd_reg, hd_next;
    logic [LVL_W-1:0]      lvlu_reg, lvlu_next;
    logic [EW:0]           e_reg, e_next;
    logic [DW-1:0]         qh_reg, qh_next;
    logic [DW-1:0]         qt_reg, qt_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [DW-1:0]         k_reg, k_next;
    logic [CAP_W-1:0]      bott_reg, bott_next;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [FLOW_W-1:0]     oflow_reg, oflow_next;
    logic [MASK_W-1:0]     omask_reg, omask_next;
    logic                  odrop_reg, odrop_next;

    // memory ports
    logic                  edge_we;
    logic [EW-1:0]         edge_waddr, edge_raddr;
    edge_word_t            edge_wdata, edge_rdata;
    logic                  lvl_we;
    logic [VAW-1:0]        lvl_waddr, lvl_raddr;
    logic [LVL_W-1:0]      lvl_wdata, lvl_rdata;
    logic                  q_we;
    logic [VAW-1:0]        q_waddr, q_raddr;
    logic [VTX_W-1:0]      q_wdata, q_rdata;
    logic                  ptr_we;
    logic [VAW-1:0]        ptr_waddr, ptr_raddr;
    logic [EW:0]           ptr_wdata, ptr_rdata;
    logic                  stk_we;
    logic [VAW-1:0]        stk_waddr, stk_raddr;
    logic [EW-1:0]         stk_wdata, stk_rdata;

    logic [LVL_W-1:0]      n_eff;
    logic [EW:0]           m_edges;
    logic                  in_take;
    logic                  in_drop;
    logic                  e_usable;
    logic                  e_live;

    mfs_ram #(.WIDTH($bits(edge_word_t)), .DEPTH(2 * MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    mfs_ram #(.WIDTH(LVL_W), .DEPTH(MAX_VERTICES)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    mfs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mfs_ram #(.WIDTH(EW + 1), .DEPTH(MAX_VERTICES)) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    mfs_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // vertex count clamped to 2..MAX_VERTICES
    always_comb
    begin
        if (vc_reg < LVL_W'(2))
        begin
            n_eff = LVL_W'(2);
        end
        else if (vc_reg > LVL_W'(MAX_VERTICES))
        begin
            n_eff = LVL_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vc_reg;
        end
    end

    assign m_edges  = {cnt_reg, 1'b0};
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign in_drop  = ({1'b0, edge_from} >= n_eff) || ({1'b0, edge_to} >= n_eff)
                      || (cnt_reg >= EW'(MAX_EDGES));

    // edge just read leaves the current vertex with spare capacity
    assign e_usable = ({1'b0, edge_rdata.tail} < n_eff) && ({1'b0, edge_rdata.head} < n_eff);
    assign e_live   = e_usable && (edge_rdata.tail == u_reg) && (edge_rdata.cap != '0);

    assign out_valid        = oval_reg;
    assign max_flow         = oflow_reg;
    assign source_side_mask = omask_reg;
    assign edges_dropped    = odrop_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        flow_next    = flow_reg;
        oval_next    = oval_reg;
        vc_next      = vc_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        ld_tail_next = ld_tail_reg;
        ld_head_next = ld_head_reg;
        ld_last_next = ld_last_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        hd_next      = hd_reg;
        lvlu_next    = lvlu_reg;
        e_next       = e_reg;
        qh_next      = qh_reg;
        qt_next      = qt_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        bott_next    = bott_reg;
        mask_next    = mask_reg;
        oflow_next   = oflow_reg;
        omask_next   = omask_reg;
        odrop_next   = odrop_reg;

        edge_we    = 1'b0;
        edge_waddr = e_reg[EW-1:0];
        edge_wdata = edge_rdata;
        edge_raddr = e_reg[EW-1:0];
        lvl_we     = 1'b0;
        lvl_waddr  = v_reg[VAW-1:0];
        lvl_wdata  = n_eff;
        lvl_raddr  = u_reg[VAW-1:0];
        q_we       = 1'b0;
        q_waddr    = qt_reg[VAW-1:0];
        q_wdata    = src_reg;
        q_raddr    = qh_reg[VAW-1:0];
        ptr_we     = 1'b0;
        ptr_waddr  = u_reg[VAW-1:0];
        ptr_wdata  = e_reg;
        ptr_raddr  = u_reg[VAW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = d_reg[VAW-1:0];
        stk_wdata  = e_reg[EW-1:0];
        stk_raddr  = k_reg[VAW-1:0];

        // result taken downstream
        if (oval_reg && !out_stall)
        begin
            oval_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: vc_next  = cfg_data;
                REG_SOURCE:       src_next = cfg_data[VTX_W-1:0];
                REG_SINK:         snk_next = cfg_data[VTX_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    ld_last_next = last_edge;
                    if (in_drop)
                    begin
                        drop_next = 1'b1;
                        if (last_edge)
                        begin
                            state_next = S_START;
                        end
                    end
                    else
                    begin
                        // forward edge now, reverse edge next cycle
                        edge_we         = 1'b1;
                        edge_waddr      = EW'({cnt_reg, 1'b0});
                        edge_wdata.tail = edge_from;
                        edge_wdata.head = edge_to;
                        edge_wdata.cap  = (capacity > AUG_CAP) ? AUG_CAP : capacity;
                        ld_tail_next    = edge_from;
                        ld_head_next    = edge_to;
                        state_next      = S_LOAD_REV;
                    end
                end
            end

            S_LOAD_REV:
            begin
                edge_we         = 1'b1;
                edge_waddr      = EW'({cnt_reg, 1'b1});
                edge_wdata.tail = ld_head_reg;
                edge_wdata.head = ld_tail_reg;
                edge_wdata.cap  = '0;
                cnt_next        = cnt_reg + EW'(1);
                state_next      = ld_last_reg ? S_START : S_IDLE;
            end

            S_START:
            begin
                flow_next = '0;
                if ({1'b0, src_reg} < n_eff)
                begin
                    state_next = S_BFS_BEG;
                end
                else
                begin
                    mask_next  = '0;
                    state_next = S_EMIT;
                end
            end

            // ---------------- level build ----------------
            S_BFS_BEG:
            begin
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = src_reg;
                qh_next    = '0;
                qt_next    = DW'(1);
                mask_next  = MASK_W'(1) << src_reg;
                v_next     = '0;
                state_next = S_LVL_INIT;
            end

            S_LVL_INIT:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = v_reg[VAW-1:0];
                lvl_wdata = (v_reg == src_reg) ? '0 : n_eff;
                v_next    = v_reg + VTX_W'(1);
                if ({1'b0, v_reg} == n_eff - LVL_W'(1))
                begin
                    state_next = S_BFS_POP;
                end
            end

            S_BFS_POP:
            begin
                if (qh_reg == qt_reg)
                begin
                    state_next = S_BFS_END;
                end
                else
                begin
                    q_raddr    = qh_reg[VAW-1:0];
                    qh_next    = qh_reg + DW'(1);
                    state_next = S_BFS_U;
                end
            end

            S_BFS_U:
            begin
                u_next     = q_rdata;
                lvl_raddr  = q_rdata[VAW-1:0];
                state_next = S_BFS_LU;
            end

            S_BFS_LU:
            begin
                lvlu_next  = lvl_rdata;
                e_next     = '0;
                state_next = S_BFS_ERD;
            end

            S_BFS_ERD:
            begin
                if (e_reg >= m_edges)
                begin
                    state_next = S_BFS_POP;
                end
                else
                begin
                    edge_raddr = e_reg[EW-1:0];
                    state_next = S_BFS_ECHK;
                end
            end

            S_BFS_ECHK:
            begin
                if (e_live)
                begin
                    hd_next    = edge_rdata.head;
                    lvl_raddr  = edge_rdata.head[VAW-1:0];
                    state_next = S_BFS_LCHK;
                end
                else
                begin
                    e_next     = e_reg + (EW + 1)'(1);
                    state_next = S_BFS_ERD;
                end
            end

            S_BFS_LCHK:
            begin
                if (lvl_rdata > lvlu_reg + LVL_W'(1))
                begin
                    lvl_we    = 1'b1;
                    lvl_waddr = hd_reg[VAW-1:0];
                    lvl_wdata = lvlu_reg + LVL_W'(1);
                    mask_next = mask_reg | (MASK_W'(1) << hd_reg);
                    if (qt_reg < DW'(MAX_VERTICES))
                    begin
                        q_we    = 1'b1;
                        q_waddr = qt_reg[VAW-1:0];
                        q_wdata = hd_reg;
                        qt_next = qt_reg + DW'(1);
                    end
                end
                e_next     = e_reg + (EW + 1)'(1);
                state_next = S_BFS_ERD;
            end

            S_BFS_END:
            begin
                // sink reachable, in range and distinct from the source means another blocking-flow phase
                if ((src_reg != snk_reg) && ({1'b0, snk_reg} < n_eff) && mask_reg[snk_reg])
                begin
                    v_next     = '0;
                    state_next = S_PTR_INIT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // ---------------- blocking flow ----------------
            S_PTR_INIT:
            begin
                ptr_we    = 1'b1;
                ptr_waddr = v_reg[VAW-1:0];
                ptr_wdata = '0;
                v_next    = v_reg + VTX_W'(1);
                if ({1'b0, v_reg} == n_eff - LVL_W'(1))
                begin
                    u_next     = src_reg;
                    d_next     = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (u_reg == snk_reg)
                begin
                    bott_next  = AUG_CAP;
                    k_next     = '0;
                    state_next = S_MIN_RD;
                end
                else
                begin
                    ptr_raddr  = u_reg[VAW-1:0];
                    lvl_raddr  = u_reg[VAW-1:0];
                    state_next = S_W_GET;
                end
            end

            S_W_GET:
            begin
                e_next     = ptr_rdata;
                lvlu_next  = lvl_rdata;
                state_next = S_W_ERD;
            end

            S_W_ERD:
            begin
                if (e_reg >= m_edges)
                begin
                    state_next = S_W_END;
                end
                else
                begin
                    edge_raddr = e_reg[EW-1:0];
                    state_next = S_W_ECHK;
                end
            end

            S_W_ECHK:
            begin
                if (e_live)
                begin
                    hd_next    = edge_rdata.head;
                    lvl_raddr  = edge_rdata.head[VAW-1:0];
                    state_next = S_W_LCHK;
                end
                else
                begin
                    e_next     = e_reg + (EW + 1)'(1);
                    state_next = S_W_ERD;
                end
            end

            S_W_LCHK:
            begin
                if (lvl_rdata == lvlu_reg + LVL_W'(1))
                begin
                    state_next = S_W_END;
                end
                else
                begin
                    e_next     = e_reg + (EW + 1)'(1);
                    state_next = S_W_ERD;
                end
            end

            S_W_END:
            begin
                ptr_we    = 1'b1;
                ptr_waddr = u_reg[VAW-1:0];
                ptr_wdata = e_reg;
                if ((e_reg < m_edges) && (d_reg < DW'(MAX_VERTICES)))
                begin
                    // advance along the admissible edge
                    stk_we     = 1'b1;
                    stk_waddr  = d_reg[VAW-1:0];
                    stk_wdata  = e_reg[EW-1:0];
                    d_next     = d_reg + DW'(1);
                    u_next     = hd_reg;
                    state_next = S_WALK;
                end
                else if ((u_reg == src_reg) || (d_reg == '0))
                begin
                    // phase over: rebuild levels
                    state_next = S_BFS_BEG;
                end
                else
                begin
                    // dead end: retreat one edge
                    stk_raddr  = d_reg[VAW-1:0] - VAW'(1);
                    d_next     = d_reg - DW'(1);
                    state_next = S_RET_STK;
                end
            end

            S_RET_STK:
            begin
                e_next     = {1'b0, stk_rdata};
                edge_raddr = stk_rdata;
                state_next = S_RET_EDGE;
            end

            S_RET_EDGE:
            begin
                // the tail's pointer still holds this edge: step past it
                u_next     = edge_rdata.tail;
                ptr_we     = 1'b1;
                ptr_waddr  = edge_rdata.tail[VAW-1:0];
                ptr_wdata  = e_reg + (EW + 1)'(1);
                state_next = S_WALK;
            end

            // ---------------- augmentation ----------------
            S_MIN_RD:
            begin
                if (k_reg == d_reg)
                begin
                    k_next     = '0;
                    state_next = S_UPD_RD;
                end
                else
                begin
                    stk_raddr  = k_reg[VAW-1:0];
                    state_next = S_MIN_STK;
                end
            end

            S_MIN_STK:
            begin
                edge_raddr = stk_rdata;
                state_next = S_MIN_CMP;
            end

            S_MIN_CMP:
            begin
                if (edge_rdata.cap < bott_reg)
                begin
                    bott_next = edge_rdata.cap;
                end
                k_next     = k_reg + DW'(1);
                state_next = S_MIN_RD;
            end

            S_UPD_RD:
            begin
                if (k_reg == d_reg)
                begin
                    flow_next  = flow_reg + FLOW_W'(bott_reg);
                    u_next     = src_reg;
                    d_next     = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    stk_raddr  = k_reg[VAW-1:0];
                    state_next = S_UPD_STK;
                end
            end

            S_UPD_STK:
            begin
                e_next     = {1'b0, stk_rdata};
                edge_raddr = stk_rdata;
                state_next = S_UPD_FWD;
            end

            S_UPD_FWD:
            begin
                edge_we        = 1'b1;
                edge_waddr     = e_reg[EW-1:0];
                edge_wdata     = edge_rdata;
                edge_wdata.cap = edge_rdata.cap - bott_reg;
                edge_raddr     = e_reg[EW-1:0] ^ EW'(1);
                state_next     = S_UPD_REV;
            end

            S_UPD_REV:
            begin
                edge_we        = 1'b1;
                edge_waddr     = e_reg[EW-1:0] ^ EW'(1);
                edge_wdata     = edge_rdata;
                edge_wdata.cap = edge_rdata.cap + bott_reg;
                k_next         = k_reg + DW'(1);
                state_next     = S_UPD_RD;
            end

            S_EMIT:
            begin
                // wait for the output register to free up
                if (!oval_reg)
                begin
                    oval_next  = 1'b1;
                    oflow_next = flow_reg;
                    omask_next = mask_reg;
                    odrop_next = drop_reg;
                    cnt_next   = '0;
                    drop_next  = 1'b0;
                    flow_next  = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            flow_reg  <= '0;
            oval_reg  <= 1'b0;
            vc_reg    <= LVL_W'(64);
            src_reg   <= '0;
            snk_reg   <= VTX_W'(63);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            flow_reg  <= flow_next;
            oval_reg  <= oval_next;
            vc_reg    <= vc_next;
            src_reg   <= src_next;
            snk_reg   <= snk_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        ld_tail_reg <= ld_tail_next;
        ld_head_reg <= ld_head_next;
        ld_last_reg <= ld_last_next;
        v_reg       <= v_next;
        u_reg       <= u_next;
        hd_reg      <= hd_next;
        lvlu_reg    <= lvlu_next;
        e_reg       <= e_next;
        qh_reg      <= qh_next;
        qt_reg      <= qt_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        bott_reg    <= bott_next;
        mask_reg    <= mask_next;
        oflow_reg   <= oflow_next;
        omask_reg   <= omask_next;
        odrop_reg   <= odrop_next;
    end

endmodule

// ----- tb/tb_max_flow_min_cut_solver_unit.sv -----
`timescale 1ns / 100ps

module tb_max_flow_min_cut_solver_unit;
    import mfs_pkg::*;

    // solve results as the block reports them
    typedef struct {
        logic [FLOW_W-1:0] flow;
        logic [MASK_W-1:0] mask;
        logic              dropped;
    } cut_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_VERTEX_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VTX_W-1:0]      edge_from = '0;
    logic [VTX_W-1:0]      edge_to = '0;
    logic [CAP_W-1:0]      capacity = '0;
    logic                  last_edge = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [FLOW_W-1:0]     max_flow;
    logic [MASK_W-1:0]     source_side_mask;
    logic                  edges_dropped;

    max_flow_min_cut_solver_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .edge_from        (edge_from),
        .edge_to          (edge_to),
        .capacity         (capacity),
        .last_edge        (last_edge),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .max_flow         (max_flow),
        .source_side_mask (source_side_mask),
        .edges_dropped    (edges_dropped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the edge store and the registers
    // ------------------------------------------------------------------
    logic [6:0]       cur_vcount = 7'd64;
    logic [VTX_W-1:0] cur_source = 6'd0;
    logic [VTX_W-1:0] cur_sink   = 6'd63;

    logic [VTX_W-1:0] arc_tail [1024];
    logic [VTX_W-1:0] arc_head [1024];
    logic [CAP_W-1:0] arc_res  [1024];
    int unsigned      arc_pairs = 0;
    bit               drop_pending = 1'b0;
    logic [FLOW_W-1:0] flow_sum;
    int unsigned      level [64];
    int unsigned      scan_ptr [64];
    int unsigned      walk [64];
    int unsigned      bfs_q [64];

    cut_result_t      pending_cuts [$];
    int               error_count = 0;
    int               requests_sent = 0;
    bit               steady = 1'b0;      // no random idling while set
    int               hold_left = 0;      // long receiver hold-off, in cycles

    function automatic int unsigned active_vertices();
        int unsigned n;
        n = 32'(cur_vcount);
        if (n < 2) n = 2;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic bit arc_live(int unsigned e, int unsigned n);
        return arc_tail[e] < n && arc_head[e] < n;
    endfunction

    // breadth-first levels from s; returns the reachable set
    function automatic logic [63:0] assign_levels(int unsigned n, int unsigned s);
        int unsigned m;
        int unsigned qh;
        int unsigned qt;
        int unsigned u;
        logic [63:0] reach;
        m = 2 * arc_pairs;
        qh = 0;
        qt = 0;
        reach = '0;
        for (int v = 0; v < n; v++) level[v] = n;
        level[s] = 0;
        bfs_q[qt++] = s;
        while (qh < qt)
        begin
            u = bfs_q[qh++];
            for (int unsigned e = 0; e < m; e++)
            begin
                if (!arc_live(e, n) || arc_tail[e] != u || arc_res[e] == 0) continue;
                if (level[arc_head[e]] <= level[u] + 1) continue;
                level[arc_head[e]] = level[u] + 1;
                if (qt < 64) bfs_q[qt++] = arc_head[e];
            end
        end
        for (int v = 0; v < n; v++)
            if (level[v] < n) reach[v] = 1'b1;
        return reach;
    endfunction

    // augmenting walks along the level graph until it is blocked
    function automatic void push_blocking_flow(int unsigned n, int unsigned s, int unsigned t);
        int unsigned m;
        int unsigned d;
        int unsigned u;
        int unsigned e;
        logic [CAP_W-1:0] bott;
        bit found;
        m = 2 * arc_pairs;
        for (int v = 0; v < n; v++) scan_ptr[v] = 0;
        forever
        begin
            d = 0;
            u = s;
            found = 1'b0;
            forever
            begin
                if (u == t)
                begin
                    found = 1'b1;
                    break;
                end
                e = scan_ptr[u];
                while (e < m)
                begin
                    if (arc_live(e, n) && arc_tail[e] == u && arc_res[e] != 0 &&
                        level[arc_head[e]] == level[u] + 1)
                        break;
                    e++;
                end
                scan_ptr[u] = e;
                if (e < m && d < 64)
                begin
                    walk[d++] = e;
                    u = arc_head[e];
                    continue;
                end
                if (u == s || d == 0) break;
                d--;
                u = arc_tail[walk[d]];
                scan_ptr[u]++;
            end
            if (!found) break;
            bott = AUG_CAP;
            for (int k = 0; k < d; k++)
                if (arc_res[walk[k]] < bott) bott = arc_res[walk[k]];
            for (int k = 0; k < d; k++)
            begin
                arc_res[walk[k]]        -= bott;
                arc_res[walk[k] ^ 1]    += bott;
            end
            flow_sum = flow_sum + FLOW_W'(bott);
        end
    endfunction

    // store one accepted edge request; a last edge solves and queues the result
    function automatic void absorb_edge(logic [VTX_W-1:0] f, logic [VTX_W-1:0] h,
                                        logic [CAP_W-1:0] c, logic fin);
        int unsigned n;
        int unsigned e;
        cut_result_t r;
        n = active_vertices();
        if (c > AUG_CAP) c = AUG_CAP;
        if (f >= n || h >= n || arc_pairs >= 512)
            drop_pending = 1'b1;
        else
        begin
            e = 2 * arc_pairs;
            arc_tail[e] = f;
            arc_head[e] = h;
            arc_res[e] = c;
            arc_tail[e + 1] = h;
            arc_head[e + 1] = f;
            arc_res[e + 1] = '0;
            arc_pairs++;
        end
        if (!fin) return;
        flow_sum = '0;
        r.mask = '0;
        if (cur_source < n)
        begin
            if (cur_source == cur_sink || cur_sink >= n)
                r.mask = assign_levels(n, cur_source);
            else
                forever
                begin
                    r.mask = assign_levels(n, cur_source);
                    if (level[cur_sink] >= n) break;
                    push_blocking_flow(n, cur_source, cur_sink);
                end
        end
        r.flow = flow_sum;
        r.dropped = drop_pending;
        pending_cuts.insert(pending_cuts.size(), r);
        arc_pairs = 0;
        drop_pending = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_edge(input logic [VTX_W-1:0] f, input logic [VTX_W-1:0] h,
                             input logic [CAP_W-1:0] c, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        edge_from <= f;
        edge_to   <= h;
        capacity  <= c;
        last_edge <= fin;
        // values read right after the edge are the ones the block sampled
        do @(posedge clk); while (in_stall);
        absorb_edge(f, h, c, fin);
        requests_sent++;
    endtask

    // drop valid, let every pending result drain, then give the block time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cuts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VERTEX_COUNT: cur_vcount = val;
            REG_SOURCE:       cur_source = val[VTX_W-1:0];
            REG_SINK:         cur_sink   = val[VTX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_graph(input int n, input int s, input int t);
        wait_idle();
        write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(n));
        write_reg(REG_SOURCE, CFG_DATA_W'(s));
        write_reg(REG_SINK, CFG_DATA_W'(t));
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, long hold-off on request, checking
    // ------------------------------------------------------------------
    initial
    begin
        int rx_wait;
        cut_result_t want;
        rx_wait = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_cuts.size() == 0)
                begin
                    $error("result with nothing expected: flow %0d", max_flow);
                    error_count++;
                end
                else
                begin
                    want = pending_cuts.pop_front();
                    if (max_flow !== want.flow)
                    begin
                        $error("max_flow: expected %0d, got %0d", want.flow, max_flow);
                        error_count++;
                    end
                    if (source_side_mask !== want.mask)
                    begin
                        $error("source_side_mask: expected %h, got %h",
                               want.mask, source_side_mask);
                        error_count++;
                    end
                    if (edges_dropped !== want.dropped)
                    begin
                        $error("edges_dropped: expected %0b, got %0b",
                               want.dropped, edges_dropped);
                        error_count++;
                    end
                end
                rx_wait = steady ? 0 : $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // small networks: a multi-path flow with a zero-capacity edge, then an unreachable sink
    task automatic test_basic_paths();
        set_graph(4, 0, 3);
        send_edge(0, 1, 10, 0);
        send_edge(0, 2, 5, 0);
        send_edge(1, 2, 15, 0);
        send_edge(1, 3, 5, 0);
        send_edge(2, 3, 10, 0);
        send_edge(2, 1, 0, 1);          // zero capacity edge
        send_edge(0, 1, 3, 0);
        send_edge(1, 2, 3, 1);          // sink unreachable
    endtask

    // capacity above the cap saturates; parallel edges exceed a single augmentation
    task automatic test_saturation();
        set_graph(2, 0, 1);
        send_edge(0, 1, 30'h3FFFFFFF, 0);
        send_edge(0, 1, AUG_CAP, 1);
    endtask

    // out-of-range edges, and source/sink corner settings
    task automatic test_ranges();
        set_graph(4, 0, 3);
        send_edge(0, 1, 7, 0);
        send_edge(63, 1, 1, 0);
        send_edge(1, 3, 7, 1);
        set_graph(4, 0, 0);             // source equals sink
        send_edge(0, 1, 5, 1);
        set_graph(4, 1, 9);             // sink out of range
        send_edge(1, 2, 5, 1);
        set_graph(4, 5, 3);             // source out of range
        send_edge(0, 3, 5, 1);
        set_graph(4, 7'h43, 7'h42);     // upper data bit is not part of the index
        send_edge(3, 2, 6, 1);
    endtask

    // vertex count below 2 and above 64
    task automatic test_vertex_limits();
        set_graph(0, 0, 1);
        send_edge(0, 1, 3, 0);
        send_edge(0, 2, 3, 1);
        set_graph(127, 0, 63);
        send_edge(0, 63, 30'h2AAAAAAA, 0);
        send_edge(0, 42, 30'h15555555, 0);
        send_edge(42, 63, 30'h3FFFFFFF, 1);
    endtask

    // vertex count lowered between loading and the solve
    task automatic test_lowered_count();
        set_graph(8, 0, 7);
        send_edge(0, 1, 4, 0);
        send_edge(0, 6, 9, 0);
        send_edge(6, 2, 9, 0);
        wait_idle();
        write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(3));
        write_reg(REG_SINK, CFG_DATA_W'(2));
        send_edge(1, 2, 4, 1);
    endtask

    // more edges than the store holds, two-vertex graph to keep the solve short
    task automatic test_edge_overflow();
        set_graph(2, 0, 1);
        for (int i = 0; i < 514; i++)
            send_edge(VTX_W'(i[0]), VTX_W'(!i[0]),
                      (i % 3 == 0) ? AUG_CAP : CAP_W'($urandom_range(1, 1000)),
                      i == 513);
    endtask

    // receiver holds off while the sender keeps offering graphs
    task automatic test_backpressure();
        set_graph(5, 0, 4);
        hold_left = 5000;
        steady = 1'b1;
        for (int g = 0; g < 4; g++)
            for (int i = 0; i < 5; i++)
                send_edge(VTX_W'($urandom_range(0, 4)), VTX_W'($urandom_range(0, 4)),
                          CAP_W'($urandom_range(0, 50)), i == 4);
        steady = 1'b0;
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return AUG_CAP;
            2:       return CAP_W'($urandom());
            3:       return CAP_W'($urandom_range(999999000, 1000001000));
            default: return CAP_W'($urandom_range(1, 20));
        endcase
    endfunction

    // random graphs, mostly small and well formed, a few wide ones and strays
    task automatic test_random_graphs();
        int n;
        int edges;
        logic [VTX_W-1:0] f;
        logic [VTX_W-1:0] h;
        while (requests_sent < 700)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 10);
            if ($urandom_range(0, 9) == 0)
                set_graph(n, $urandom_range(0, 127), $urandom_range(0, 127));
            else
                set_graph(n, $urandom_range(0, 1), (n > 2) ? n - 1 : 1);
            steady = ($urandom_range(0, 4) == 0);
            edges = $urandom_range(1, 10);
            for (int i = 0; i < edges; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    f = VTX_W'($urandom());
                    h = VTX_W'($urandom());
                end
                else
                begin
                    f = VTX_W'($urandom_range(0, active_vertices() - 1));
                    h = VTX_W'($urandom_range(0, active_vertices() - 1));
                end
                send_edge(f, h, pick_capacity(), i == edges - 1);
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_paths();
        test_saturation();
        test_ranges();
        test_vertex_limits();
        test_lowered_count();
        test_edge_overflow();
        test_backpressure();
        test_random_graphs();
        wait_idle();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb_max_flow_min_cut_solver_unit: done, clean");
        else
            $display("tb_max_flow_min_cut_solver_unit: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("tb_max_flow_min_cut_solver_unit: done, errors");
        $finish;
    end

endmodule
